[sv/md5_pkg.sv]
`default_nettype none

package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] PAD_LIMIT  = 6'd55;
  localparam logic [1:0] WORD_D     = 2'd3;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_PAD2,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_BYTE,
    PH_BYTE_LAST,
    PH_PAD_LONG,
    PH_PAD_END
  } phase_t;

  typedef enum logic [1:0] {
    RG_F,
    RG_G,
    RG_H,
    RG_I
  } round_grp_t;

  typedef struct packed {
    logic       take_byte;
    logic       init_work;
    logic       round_en;
    logic [5:0] rnd;
    logic       add_chain;
    logic       pad_first;
    logic       pad_second;
    logic       finish;
    logic [1:0] widx;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pad_long;
  } status_t;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by round i; all index math is modulo 16.
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    case (round_grp_t'(i[5:4]))
      RG_F:    g = lo;
      RG_G:    g = 4'((lo << 2) + lo + 4'd1);
      RG_H:    g = 4'((lo << 1) + lo + 4'd5);
      RG_I:    g = 4'((lo << 3) - lo);
      default: g = lo;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[sv/md5_if.sv]
`default_nettype none

interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last_byte,
                output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

`default_nettype wire

[sv/md5_datapath.sv]
`default_nettype none

module md5_datapath (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  [7:0]           data_byte,
  input  wire md5_pkg::cmd_t   cmd,
  output md5_pkg::status_t     status,
  output logic [31:0]          digest_word
);

  logic [31:0] blk_r [16];
  logic [31:0] blk_nxt [16];
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [63:0] count_r;
  logic [63:0] count_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic [31:0] f_val;
  logic [31:0] sum_val;
  logic [63:0] rot_wide;
  logic [31:0] rot_val;
  logic [31:0] head_word;

  assign pos     = count_r[5:0];
  assign bit_len = {count_r[60:0], 3'b000};

  assign status.pos_last = (pos == md5_pkg::LAST_POS);
  assign status.pad_long = (pos > md5_pkg::PAD_LIMIT);

  assign digest_word = chain_r[cmd.widx];

  // Word that holds the end-of-message marker: earlier bytes kept, marker, zeros.
  always_comb begin
    case (pos[1:0])
      2'd0:    head_word = {24'h0, md5_pkg::PAD_BYTE};
      2'd1:    head_word = {16'h0, md5_pkg::PAD_BYTE, blk_r[pos[5:2]][7:0]};
      2'd2:    head_word = {8'h0, md5_pkg::PAD_BYTE, blk_r[pos[5:2]][15:0]};
      2'd3:    head_word = {md5_pkg::PAD_BYTE, blk_r[pos[5:2]][23:0]};
      default: head_word = 32'h0;
    endcase
  end

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blk_nxt[j] = blk_r[j];
    end
    if (cmd.take_byte) begin
      case (pos[1:0])
        2'd0:    blk_nxt[pos[5:2]] = {24'h0, data_byte};
        2'd1:    blk_nxt[pos[5:2]][15:8] = data_byte;
        2'd2:    blk_nxt[pos[5:2]][23:16] = data_byte;
        2'd3:    blk_nxt[pos[5:2]][31:24] = data_byte;
        default: blk_nxt[pos[5:2]] = blk_r[pos[5:2]];
      endcase
    end
    if (cmd.pad_first) begin
      for (int j = 0; j < 16; j++) begin
        if (4'(j) == pos[5:2]) begin
          blk_nxt[j] = head_word;
        end else if (4'(j) > pos[5:2]) begin
          blk_nxt[j] = 32'h0;
        end
      end
      if (!status.pad_long) begin
        blk_nxt[14] = bit_len[31:0];
        blk_nxt[15] = bit_len[63:32];
      end
    end
    if (cmd.pad_second) begin
      for (int j = 0; j < 14; j++) begin
        blk_nxt[j] = 32'h0;
      end
      blk_nxt[14] = bit_len[31:0];
      blk_nxt[15] = bit_len[63:32];
    end
  end

  always_comb begin
    case (md5_pkg::round_grp_t'(cmd.rnd[5:4]))
      md5_pkg::RG_F: f_val = (b_r & c_r) | (~b_r & d_r);
      md5_pkg::RG_G: f_val = (d_r & b_r) | (~d_r & c_r);
      md5_pkg::RG_H: f_val = b_r ^ c_r ^ d_r;
      md5_pkg::RG_I: f_val = c_r ^ (b_r | ~d_r);
      default:       f_val = 32'h0;
    endcase
    sum_val  = a_r + f_val + md5_pkg::sine_k(cmd.rnd) + blk_r[md5_pkg::msg_index(cmd.rnd)];
    rot_wide = {sum_val, sum_val} << md5_pkg::rot_amt({cmd.rnd[5:4], cmd.rnd[1:0]});
    rot_val  = rot_wide[63:32];
  end

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    if (cmd.init_work) begin
      a_nxt = chain_r[0];
      b_nxt = chain_r[1];
      c_nxt = chain_r[2];
      d_nxt = chain_r[3];
    end else if (cmd.round_en) begin
      a_nxt = d_r;
      b_nxt = b_r + rot_val;
      c_nxt = b_r;
      d_nxt = c_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      chain_nxt[k] = chain_r[k];
    end
    count_nxt = count_r;
    if (cmd.take_byte) begin
      count_nxt = count_r + 64'd1;
    end
    if (cmd.add_chain) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
    end
    if (cmd.finish) begin
      chain_nxt[0] = md5_pkg::IV_A;
      chain_nxt[1] = md5_pkg::IV_B;
      chain_nxt[2] = md5_pkg::IV_C;
      chain_nxt[3] = md5_pkg::IV_D;
      count_nxt    = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= md5_pkg::IV_A;
      chain_r[1] <= md5_pkg::IV_B;
      chain_r[2] <= md5_pkg::IV_C;
      chain_r[3] <= md5_pkg::IV_D;
      count_r    <= 64'd0;
    end else begin
      chain_r <= chain_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
  end

endmodule

`default_nettype wire

[sv/md5_ctrl.sv]
`default_nettype none

module md5_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_has,
  input  wire               in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  wire md5_pkg::status_t status,
  output md5_pkg::cmd_t     cmd
);

  md5_pkg::state_t state_r, state_nxt;
  md5_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]      rnd_r, rnd_nxt;
  logic [1:0]      widx_r, widx_nxt;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    rnd_nxt   = rnd_r;
    widx_nxt  = widx_r;
    case (state_r)
      md5_pkg::ST_IDLE: begin
        rnd_nxt  = 6'd0;
        widx_nxt = 2'd0;
        if (in_acc) begin
          if (in_has && status.pos_last) begin
            state_nxt = md5_pkg::ST_ROUND;
            phase_nxt = in_last ? md5_pkg::PH_BYTE_LAST : md5_pkg::PH_BYTE;
          end else if (in_last) begin
            state_nxt = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == md5_pkg::LAST_ROUND) begin
          state_nxt = md5_pkg::ST_ADD;
        end
      end
      md5_pkg::ST_ADD: begin
        case (phase_r)
          md5_pkg::PH_BYTE:      state_nxt = md5_pkg::ST_IDLE;
          md5_pkg::PH_BYTE_LAST: state_nxt = md5_pkg::ST_PAD;
          md5_pkg::PH_PAD_LONG:  state_nxt = md5_pkg::ST_PAD2;
          md5_pkg::PH_PAD_END:   state_nxt = md5_pkg::ST_OUT;
          default:               state_nxt = md5_pkg::ST_IDLE;
        endcase
      end
      md5_pkg::ST_PAD: begin
        state_nxt = md5_pkg::ST_ROUND;
        phase_nxt = status.pad_long ? md5_pkg::PH_PAD_LONG : md5_pkg::PH_PAD_END;
      end
      md5_pkg::ST_PAD2: begin
        state_nxt = md5_pkg::ST_ROUND;
        phase_nxt = md5_pkg::PH_PAD_END;
      end
      md5_pkg::ST_OUT: begin
        if (out_acc) begin
          widx_nxt = widx_r + 2'd1;
          if (widx_r == md5_pkg::WORD_D) begin
            state_nxt = md5_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == md5_pkg::ST_IDLE);
    out_valid      = (state_r == md5_pkg::ST_OUT);
    cmd            = '0;
    cmd.rnd        = rnd_r;
    cmd.widx       = widx_r;
    cmd.take_byte  = in_acc && in_has;
    cmd.init_work  = (in_acc && in_has && status.pos_last) ||
                     (state_r == md5_pkg::ST_PAD) || (state_r == md5_pkg::ST_PAD2);
    cmd.round_en   = (state_r == md5_pkg::ST_ROUND);
    cmd.add_chain  = (state_r == md5_pkg::ST_ADD);
    cmd.pad_first  = (state_r == md5_pkg::ST_PAD);
    cmd.pad_second = (state_r == md5_pkg::ST_PAD2);
    cmd.finish     = out_acc && (widx_r == md5_pkg::WORD_D);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5_pkg::ST_IDLE;
      phase_r <= md5_pkg::PH_BYTE;
      rnd_r   <= 6'd0;
      widx_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
    end
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output handshakes active together");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_has && status.pos_last) |=> (state_r == md5_pkg::ST_ROUND) && (rnd_r == 6'd0))
    else $error("full block did not start compression");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::ST_ROUND && rnd_r == md5_pkg::LAST_ROUND) |=>
    (state_r == md5_pkg::ST_ADD))
    else $error("compression did not end after the last round");

  a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && widx_r == md5_pkg::WORD_D) |=> in_ready)
    else $error("engine not ready after the final digest word");

  a_out_from_pad: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == md5_pkg::ST_ADD) &&
    ($past(phase_r) == md5_pkg::PH_PAD_END) && (widx_r == 2'd0))
    else $error("digest output started outside the final block");

endmodule

`default_nettype wire

[sv/md5_hash_engine_top.sv]
// A byte transaction that does not complete a block leaves the engine idle and ready.
// A byte that completes a 64-byte block holds the input while the
// compression unit runs its 64 rounds, one per cycle, and adds into the chaining words.
// A last transaction adds padding and compression (a second padded block when the
// length spills over), then four digest words.
// Reset is synchronous, active low: initial vector loaded, byte count cleared.
`default_nettype none

module md5_hash_engine_top (
  input  wire        clk,
  input  wire        rst_n,
  md5_in_if.sink     in_ch,
  md5_out_if.source  out_ch
);

  md5_pkg::cmd_t    cmd;
  md5_pkg::status_t status;
  logic [31:0]      digest_word;

  md5_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_has    (in_ch.has_byte),
    .in_last   (in_ch.last_byte),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  md5_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .status      (status),
    .digest_word (digest_word)
  );

  assign out_ch.digest_word = digest_word;
  assign out_ch.word_index  = cmd.widx;
  assign out_ch.last_word   = (cmd.widx == md5_pkg::WORD_D);

endmodule

`default_nettype wire

[sim/tb.sv]
module tb;

  localparam int LONG_HOLD = 300;
  localparam int DRAIN_WAIT = 150;
  localparam int MIN_ITEMS = 180;
  localparam int MIN_MESSAGES = 10;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROT_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  word_idx;
    logic        last;
  } digest_word_t;

  class digest_checker;
    logic [31:0]  chain [4];
    logic [31:0]  blk [16];
    logic [63:0]  byte_count;
    digest_word_t expected_words [$];
    int           errors;
    int           words_checked;
    int           messages_noted;

    function new();
      load_iv();
      byte_count = '0;
      foreach (blk[i]) blk[i] = '0;
      errors = 0;
      words_checked = 0;
      messages_noted = 0;
    endfunction

    function void load_iv();
      chain[0] = INIT_A;
      chain[1] = INIT_B;
      chain[2] = INIT_C;
      chain[3] = INIT_D;
    endfunction

    function void put_byte(int pos, logic [7:0] v);
      int w;
      w = pos / 4;
      if (pos % 4 == 0) begin
        blk[w] = {24'b0, v};
      end else begin
        blk[w] = blk[w] | (32'(v) << (8 * (pos % 4)));
      end
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, t, sum;
      int g;
      int s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
        case (i / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = i;
          end
          1: begin
            f = (d & b) | (~d & c);
            g = (5 * i + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * i + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * i) % 16;
          end
        endcase
        sum = a + f + SINE_K[i] + blk[g];
        s = ROT_S[(i / 16) * 4 + i % 4];
        t = d;
        d = c;
        c = b;
        b = b + ((sum << s) | (sum >> (32 - s)));
        a = t;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
    endfunction

    function void note_transaction(logic [7:0] data, logic has, logic last);
      int pos;
      logic [63:0] bits;
      digest_word_t dw;
      if (has) begin
        pos = int'(byte_count[5:0]);
        put_byte(pos, data);
        byte_count = byte_count + 64'd1;
        if (pos == 63) compress();
      end
      if (!last) return;
      pos = int'(byte_count[5:0]);
      put_byte(pos, 8'h80);
      pos++;
      if (pos > 56) begin
        for (int p = pos; p < 64; p++) put_byte(p, 8'h00);
        compress();
        pos = 0;
      end
      for (int p = pos; p < 56; p++) put_byte(p, 8'h00);
      bits = byte_count << 3;
      blk[14] = bits[31:0];
      blk[15] = bits[63:32];
      compress();
      for (int k = 0; k < 4; k++) begin
        dw.word = chain[k];
        dw.word_idx = 2'(k);
        dw.last = (k == 3);
        expected_words.push_back(dw);
      end
      load_iv();
      byte_count = '0;
      messages_noted++;
    endfunction

    function void check_digest_word(logic [31:0] word, logic [1:0] word_idx, logic last);
      digest_word_t exp_w;
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h (index %0d)", word, word_idx);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (word !== exp_w.word) begin
        $error("digest_word mismatch: expected %h, got %h", exp_w.word, word);
        errors++;
      end
      if (word_idx !== exp_w.word_idx) begin
        $error("word_index mismatch: expected %0d, got %0d", exp_w.word_idx, word_idx);
        errors++;
      end
      if (last !== exp_w.last) begin
        $error("last_word mismatch: expected %0b, got %0b", exp_w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  bit   hold_out_req;
  int   items_sent;
  int   long_lengths;

  digest_checker sb;

  md5_in_if  in_if ();
  md5_out_if out_if ();

  md5_hash_engine_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_transaction(in_if.data_byte, in_if.has_byte, in_if.last_byte);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_digest_word(out_if.digest_word, out_if.word_index, out_if.last_word);
    end
  end

  // The receiver stalls in random bursts and once holds off for a long stretch.
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [7:0] data, input logic has, input logic last);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= data;
    in_if.has_byte <= has;
    in_if.last_byte <= last;
    do @(posedge clk); while (!in_if.ready);
    if (has || last) items_sent++;
  endtask

  task automatic send_message(input int len);
    logic end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int n = 0; n < len; n++) begin
      if (!calm && $urandom_range(0, 7) == 0) offer(8'($urandom), 1'b0, 1'b0);
      offer(8'($urandom), 1'b1, end_on_byte && (n == len - 1));
    end
    if (!end_on_byte) offer(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic int random_length();
    if ($urandom_range(0, 7) == 0) begin
      long_lengths++;
      return $urandom_range(25, 70);
    end
    return $urandom_range(0, 24);
  endfunction

  initial begin
    int boundary_lens [3];
    sb = new();
    boundary_lens = '{55, 56, 64};
    calm = 1'b0;
    hold_out_req = 1'b0;
    items_sent = 0;
    long_lengths = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.has_byte <= 1'b0;
    in_if.last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle transaction, the empty message, then short messages of up to three bytes.
    offer(8'hff, 1'b0, 1'b0);
    offer(8'h00, 1'b0, 1'b1);
    offer(8'h61, 1'b1, 1'b0);
    offer(8'h62, 1'b1, 1'b0);
    offer(8'h63, 1'b1, 1'b1);
    offer(8'h00, 1'b1, 1'b0);
    offer(8'hff, 1'b0, 1'b1);
    offer(8'hff, 1'b1, 1'b1);
    offer(8'h12, 1'b1, 1'b0);
    offer(8'haa, 1'b0, 1'b0);
    offer(8'h34, 1'b1, 1'b1);

    // These lengths hit the single-block limit, the two-block spill and full blocks.
    foreach (boundary_lens[i]) send_message(boundary_lens[i]);

    // Two messages are offered back to back while the output is held off.
    hold_out_req = 1'b1;
    send_message($urandom_range(2, 5));
    send_message($urandom_range(2, 5));
    wait_drain();

    while (items_sent < MIN_ITEMS || sb.messages_noted < MIN_MESSAGES) begin
      send_message(random_length());
    end

    calm = 1'b1;
    repeat (2) send_message($urandom_range(0, 6));
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Hashed %0d messages from %0d byte or end transactions; %0d digest words checked.",
             sb.messages_noted, items_sent, sb.words_checked);
    $display("Included empty and boundary-length messages, %0d longer ones and one %0d-cycle"
             , long_lengths, LONG_HOLD, " output hold.");
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[md5_hash_engine_top.f]
sv/md5_pkg.sv
sv/md5_if.sv
sv/md5_datapath.sv
sv/md5_ctrl.sv
sv/md5_hash_engine_top.sv
sim/tb.sv
